// ===== hw/rtl/dnt_pkg.sv =====
// ----------------------------------------------------------------------------
// dnt_pkg
// Shared constants, types and helpers for the decimal number tokeniser.
// ----------------------------------------------------------------------------
package dnt_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int INT_BITS        = 16;
	localparam int MAX_FRAC_DIGITS = 9;

	localparam int MAG_W    = INT_BITS + FRAC_BITS;
	localparam int FACC_W   = 30;
	localparam int FDIG_W   = 4;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int CNT_W    = (FRAC_BITS > 1) ? $clog2(FRAC_BITS) : 1;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_NO_DIGITS = 2'd1,
		STATUS_SATURATED = 2'd2
	} status_t;

	typedef struct packed {
		logic                sign;
		logic                digit;
		logic                point;
		logic                ovf;
		logic [INT_BITS-1:0] int_acc;
		logic [FACC_W-1:0]   frac_acc;
		logic [FDIG_W-1:0]   frac_dig;
	} num_t;

	typedef struct packed {
		logic accept;
		logic div_load;
		logic div_step;
		logic load_num;
		logic load_stray;
		logic num_last;
	} cmd_t;

	typedef struct packed {
		logic emit_num;
		logic emit_stray;
		logic out_free;
	} sts_t;

	function automatic logic [FACC_W-1:0] pow10(input logic [FDIG_W-1:0] n);
		logic [FACC_W-1:0] r;
		begin
			case (n)
				4'd0:    r = 30'd1;
				4'd1:    r = 30'd10;
				4'd2:    r = 30'd100;
				4'd3:    r = 30'd1000;
				4'd4:    r = 30'd10000;
				4'd5:    r = 30'd100000;
				4'd6:    r = 30'd1000000;
				4'd7:    r = 30'd10000000;
				4'd8:    r = 30'd100000000;
				default: r = 30'd1000000000;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== hw/rtl/dnt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dnt_ctrl
// Sequencer: takes words, runs the fraction divider, hands out results.
// ----------------------------------------------------------------------------
module dnt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  dnt_pkg::sts_t sts,
	output dnt_pkg::cmd_t cmd
);
	import dnt_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_NUM,
		ST_STRAY
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             stray_q;
	logic             accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd            = '0;
		cmd.accept     = accept;
		cmd.div_load   = accept && sts.emit_num;
		cmd.div_step   = (state_q == ST_DIV);
		cmd.load_num   = (state_q == ST_NUM) && sts.out_free;
		cmd.load_stray = (state_q == ST_STRAY) && sts.out_free;
		cmd.num_last   = !stray_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			stray_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						stray_q <= sts.emit_stray;
						if (sts.emit_num) begin
							state_q <= ST_DIV;
							cnt_q   <= CNT_W'(FRAC_BITS - 1);
						end else if (sts.emit_stray) begin
							state_q <= ST_STRAY;
						end
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_NUM;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				ST_NUM: begin
					if (sts.out_free) begin
						state_q <= stray_q ? ST_STRAY : ST_IDLE;
					end
				end
				ST_STRAY: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
						stray_q <= 1'b0;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && cnt_q == '0) |=> (state_q == ST_NUM))
		else $error("divider did not hand over to result stage");

	a_one_load: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_num && cmd.load_stray))
		else $error("two results loaded at once");

	a_stray_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_num && stray_q) |=> (state_q == ST_STRAY))
		else $error("stray result lost after number");

endmodule

// ===== hw/rtl/dnt_scan.sv =====
// ----------------------------------------------------------------------------
// dnt_scan
// Byte classifier and number accumulators (integer, fraction, flags).
// ----------------------------------------------------------------------------
module dnt_scan (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [7:0]    char_code,
	input  logic          end_of_text,
	input  dnt_pkg::cmd_t cmd,
	output logic          emit_num,
	output logic          emit_stray,
	output dnt_pkg::num_t num
);
	import dnt_pkg::*;

	typedef enum logic [1:0] {
		MODE_SKIP    = 2'd0,
		MODE_COMMENT = 2'd1,
		MODE_NUMBER  = 2'd2
	} mode_t;

	mode_t mode_q, mode_d;
	num_t  num_q, num_d, base;

	logic                  is_ws, is_hash, is_minus, is_dot, is_digit, is_start;
	logic                  ok, handled, apply;
	logic [3:0]            dval;
	logic [INT_BITS+3:0]   int_v;
	logic [FACC_W+3:0]     frac_v;

	assign num = num_q;

	always_comb begin
		is_ws    = (char_code == CH_SPACE) || (char_code == CH_TAB) ||
			(char_code == CH_CR) || (char_code == CH_LF);
		is_hash  = (char_code == CH_HASH);
		is_minus = (char_code == CH_MINUS);
		is_dot   = (char_code == CH_DOT);
		is_digit = (char_code >= CH_0) && (char_code <= CH_9);
		is_start = is_minus || is_dot || is_digit;
		dval     = 4'(char_code - CH_0);

		ok = (is_minus && !(num_q.sign || num_q.digit)) || is_digit ||
			(is_dot && !num_q.point);

		handled    = 1'b0;
		apply      = 1'b0;
		emit_num   = 1'b0;
		emit_stray = 1'b0;
		mode_d     = mode_q;

		if (end_of_text) begin
			emit_num = (mode_q == MODE_NUMBER);
			mode_d   = MODE_SKIP;
		end else if (mode_q == MODE_COMMENT) begin
			if (char_code == CH_LF) begin
				mode_d = MODE_SKIP;
			end
		end else begin
			handled  = (mode_q == MODE_NUMBER) && ok;
			emit_num = (mode_q == MODE_NUMBER) && !ok;
			if (handled) begin
				apply = 1'b1;
			end else if (is_ws) begin
				mode_d = MODE_SKIP;
			end else if (is_hash) begin
				mode_d = MODE_COMMENT;
			end else if (is_start) begin
				mode_d = MODE_NUMBER;
				apply  = 1'b1;
			end else begin
				mode_d     = MODE_SKIP;
				emit_stray = 1'b1;
			end
		end

		base   = handled ? num_q : '0;
		int_v  = (INT_BITS+4)'(base.int_acc) * (INT_BITS+4)'(10) + (INT_BITS+4)'(dval);
		frac_v = (FACC_W+4)'(base.frac_acc) * (FACC_W+4)'(10) + (FACC_W+4)'(dval);
		num_d  = base;

		if (apply) begin
			if (is_minus) begin
				num_d.sign = 1'b1;
			end else if (is_dot) begin
				num_d.point = 1'b1;
			end else if (is_digit) begin
				num_d.digit = 1'b1;
				if (base.point) begin
					if (base.frac_dig < FDIG_W'(MAX_FRAC_DIGITS)) begin
						num_d.frac_acc = frac_v[FACC_W-1:0];
						num_d.frac_dig = base.frac_dig + 1'b1;
					end
				end else if (!base.ovf) begin
					if (int_v[INT_BITS+3:INT_BITS] != '0) begin
						num_d.ovf     = 1'b1;
						num_d.int_acc = '1;
					end else begin
						num_d.int_acc = int_v[INT_BITS-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_SKIP;
			num_q  <= '0;
		end else if (cmd.accept) begin
			mode_q <= mode_d;
			num_q  <= num_d;
		end
	end

endmodule

// ===== hw/rtl/dnt_emit.sv =====
// ----------------------------------------------------------------------------
// dnt_emit
// Fraction divider (one quotient bit a cycle), fixed-point assembly,
// saturation and output register.
// ----------------------------------------------------------------------------
module dnt_emit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dnt_pkg::cmd_t                         cmd,
	input  dnt_pkg::num_t                         num,
	output logic                                  out_free,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [dnt_pkg::VALUE_W-1:0]    value,
	output logic        [dnt_pkg::STATUS_W-1:0]   status,
	output logic                                  last_result
);
	import dnt_pkg::*;

	localparam logic [63:0] HALF = 64'd1 << (MAG_W - 1);

	logic                 sign_q, digit_q, ovf_q;
	logic [INT_BITS-1:0]  int_q;
	logic [FACC_W-1:0]    rem_q, div_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [FACC_W:0]      rem2;
	logic                 ge;

	logic                 out_valid_q, last_q;
	logic [VALUE_W-1:0]   value_q;
	status_t              status_q;

	logic [63:0]          mag, res;
	logic                 sat;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = (rem2 >= {1'b0, div_q});

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			sign_q  <= num.sign;
			digit_q <= num.digit;
			ovf_q   <= num.ovf;
			int_q   <= num.int_acc;
			rem_q   <= num.frac_acc;
			div_q   <= pow10(num.frac_dig);
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? FACC_W'(rem2 - {1'b0, div_q}) : rem2[FACC_W-1:0];
			quo_q <= {quo_q[FRAC_BITS-2:0], ge};
		end
	end

	always_comb begin
		mag = 64'({int_q, quo_q});
		sat = ovf_q || (sign_q ? (mag > HALF) : (mag > HALF - 64'd1));
		if (sat) begin
			res = sign_q ? (64'd0 - HALF) : (HALF - 64'd1);
		end else begin
			res = sign_q ? (64'd0 - mag) : mag;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_num || cmd.load_stray) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_num) begin
			last_q <= cmd.num_last;
			if (!digit_q) begin
				value_q  <= '0;
				status_q <= STATUS_NO_DIGITS;
			end else begin
				value_q  <= res[VALUE_W-1:0];
				status_q <= sat ? STATUS_SATURATED : STATUS_OK;
			end
		end else if (cmd.load_stray) begin
			last_q   <= 1'b1;
			value_q  <= '0;
			status_q <= STATUS_NO_DIGITS;
		end
	end

	assign out_valid   = out_valid_q;
	assign value       = value_q;
	assign status      = status_q;
	assign last_result = last_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_num || cmd.load_stray) |-> (!out_valid_q || !out_stall))
		else $error("waiting result overwritten");

	a_no_digits_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q == STATUS_NO_DIGITS) |-> (value_q == '0))
		else $error("no-number result carries a value");

	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !(cmd.load_num || cmd.load_stray || cmd.div_load))
		else $error("divider stepped while loading");

endmodule

// ===== hw/rtl/decimal_number_tokenizer.sv =====
// ----------------------------------------------------------------------------
// decimal_number_tokenizer
// Text bytes in, signed Q16.16 numbers with status out.
//
// channel  direction  handshake            payload
// in       sink       in_valid / in_stall   char_code, end_of_text
// out      source     out_valid / out_stall value, status, last_result
//
// A word that yields no result does not stall the input. A word that ends a
// number stalls it through the DIV and NUM states: the fraction is divided by
// a power of ten one quotient bit per cycle, then the Q16.16 result is loaded.
// A stray-byte result, alone or after a number, adds the STRAY state. Input is
// stalled while results are produced or wait for an output held by out_stall.
// Reset is asynchronous and empties the output register.
// ----------------------------------------------------------------------------
module decimal_number_tokenizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [7:0]                          char_code,
	input  logic                                end_of_text,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [dnt_pkg::VALUE_W-1:0]  value,
	output logic        [dnt_pkg::STATUS_W-1:0] status,
	output logic                                last_result
);
	import dnt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	num_t num;
	logic emit_num, emit_stray, out_free;

	always_comb begin
		sts            = '0;
		sts.emit_num   = emit_num;
		sts.emit_stray = emit_stray;
		sts.out_free   = out_free;
	end

	dnt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dnt_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.cmd         (cmd),
		.emit_num    (emit_num),
		.emit_stray  (emit_stray),
		.num         (num)
	);

	dnt_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.num         (num),
		.out_free    (out_free),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.status      (status),
		.last_result (last_result)
	);

endmodule

// ===== test/number_token_checker.sv =====
// ----------------------------------------------------------------------------
// number_token_checker
// Watches both channels of the tokeniser, predicts every value, status and last
// flag from the accepted text words and compares them, in order, with the results.
// ----------------------------------------------------------------------------
module number_token_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [7:0]                          char_code,
	input  logic                                end_of_text,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic signed [dnt_pkg::VALUE_W-1:0]  value,
	input  logic        [dnt_pkg::STATUS_W-1:0] status,
	input  logic                                last_result,
	output int                                  mismatches,
	output int                                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import dnt_pkg::*;

	typedef enum logic [1:0] {
		SCAN_SKIP    = 2'd0,
		SCAN_COMMENT = 2'd1,
		SCAN_NUMBER  = 2'd2
	} scan_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		status_t                   status;
		logic                      last;
	} token_result_t;

	token_result_t expected_numbers[$];

	scan_t               scan;
	logic                neg;
	logic                got_digit;
	logic                got_point;
	logic [INT_BITS-1:0] int_acc;
	logic                int_ovf;
	logic [FACC_W-1:0]   frac_acc;
	logic [FDIG_W-1:0]   frac_dig;

	function automatic void clear_number();
		neg       = 1'b0;
		got_digit = 1'b0;
		got_point = 1'b0;
		int_acc   = '0;
		int_ovf   = 1'b0;
		frac_acc  = '0;
		frac_dig  = '0;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	// Folds one byte into the number being built; 0 means the byte ends it.
	function automatic logic number_takes(input logic [7:0] c);
		logic [63:0] v;
		logic [63:0] d;
		d = 64'(c - CH_0);
		if (c == CH_MINUS) begin
			if (neg || got_digit)
				return 1'b0;
			neg = 1'b1;
			return 1'b1;
		end
		if (is_digit(c)) begin
			got_digit = 1'b1;
			if (got_point) begin
				if (frac_dig < MAX_FRAC_DIGITS) begin
					frac_acc = FACC_W'(64'(frac_acc) * 10 + d);
					frac_dig = frac_dig + 1'b1;
				end
			end else if (!int_ovf) begin
				v = 64'(int_acc) * 10 + d;
				if (v > (64'd1 << INT_BITS) - 1) begin
					int_ovf = 1'b1;
					v = (64'd1 << INT_BITS) - 1;
				end
				int_acc = INT_BITS'(v);
			end
			return 1'b1;
		end
		if (c == CH_DOT) begin
			if (got_point)
				return 1'b0;
			got_point = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic token_result_t number_result();
		token_result_t r;
		logic [63:0]   half;
		logic [63:0]   limit;
		logic [63:0]   div;
		logic [63:0]   frac;
		logic [63:0]   mag;
		int            i;
		r.last = 1'b0;
		if (!got_digit) begin
			r.value  = '0;
			r.status = STATUS_NO_DIGITS;
			return r;
		end
		half  = 64'd1 << (MAG_W - 1);
		limit = neg ? half : half - 1;
		div   = 64'd1;
		for (i = 0; i < frac_dig && i < 9; i++)
			div = div * 10;
		frac = (64'(frac_acc) << FRAC_BITS) / div;
		mag  = (64'(int_acc) << FRAC_BITS) + frac;
		if (int_ovf || mag > limit) begin
			r.value  = VALUE_W'(neg ? 64'd0 - half : half - 1);
			r.status = STATUS_SATURATED;
		end else begin
			r.value  = VALUE_W'(neg ? 64'd0 - mag : mag);
			r.status = STATUS_OK;
		end
		return r;
	endfunction

	task automatic predict_word(input logic [7:0] c, input logic eot);
		token_result_t found[$];
		token_result_t stray;
		logic          taken;
		stray.value  = '0;
		stray.status = STATUS_NO_DIGITS;
		stray.last   = 1'b0;
		if (eot) begin
			if (scan == SCAN_NUMBER)
				found.push_back(number_result());
			scan = SCAN_SKIP;
			clear_number();
		end else if (scan == SCAN_COMMENT) begin
			if (c == CH_LF)
				scan = SCAN_SKIP;
		end else begin
			taken = 1'b0;
			if (scan == SCAN_NUMBER) begin
				if (number_takes(c)) begin
					taken = 1'b1;
				end else begin
					found.push_back(number_result());
					clear_number();
					scan = SCAN_SKIP;
				end
			end
			if (!taken) begin
				scan = SCAN_SKIP;
				if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
				end else if (c == CH_HASH) begin
					scan = SCAN_COMMENT;
				end else if (c == CH_MINUS || c == CH_DOT || is_digit(c)) begin
					clear_number();
					scan = SCAN_NUMBER;
					void'(number_takes(c));
				end else begin
					found.push_back(stray);
				end
			end
		end
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[k])
			expected_numbers.push_back(found[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		token_result_t want;
		if (!arst_n) begin
			expected_numbers.delete();
			scan = SCAN_SKIP;
			clear_number();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_numbers.size() == 0) begin
					$error("unexpected result: value %0d, status %0d", value, status);
					mismatches++;
				end else begin
					want = expected_numbers.pop_front();
					if (value !== want.value) begin
						$error("value: expected %0d, got %0d", want.value, value);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (last_result !== want.last) begin
						$error("last_result: expected %0d, got %0d", want.last, last_result);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				predict_word(char_code, end_of_text);
			outstanding = expected_numbers.size();
		end
	end

endmodule

// ===== test/decimal_number_tokenizer_tb.sv =====
// ----------------------------------------------------------------------------
// decimal_number_tokenizer_tb
// Feeds text words to the tokeniser: a directed run over the special cases,
// then random numbers, comments, terminators and noise, with random idling on
// both channels, one long output hold-off and one drain pause.
// ----------------------------------------------------------------------------
module decimal_number_tokenizer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import dnt_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_WORDS = 1950;
	localparam int DRAIN_CYCLES = FRAC_BITS + 6;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_CYCLES  = 400;
	localparam int PAUSE_AT     = 1300;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        in_valid = 1'b0;
	logic                        in_stall;
	logic [7:0]                  char_code = 8'd0;
	logic                        end_of_text = 1'b0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic signed [VALUE_W-1:0]   value;
	logic        [STATUS_W-1:0]  status;
	logic                        last_result;

	int   mismatches;
	int   outstanding;
	int   words_sent = 0;
	int   cycles = 0;
	logic idle_on = 1'b1;

	decimal_number_tokenizer uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.status     (status),
		.last_result(last_result)
	);

	number_token_checker check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.char_code  (char_code),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.status     (status),
		.last_result(last_result),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off to back the block up
	initial begin : receiver
		logic held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && words_sent >= HOLD_AT) begin
				held = 1'b1;
				out_stall = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			out_stall = idle_on && ($urandom_range(99) < 16);
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_word(input logic [7:0] c, input logic eot);
		while (idle_on && $urandom_range(99) < 16) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid    = 1'b1;
		char_code   = c;
		end_of_text = eot;
		do
			@(posedge clk);
		while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	task automatic send_digits(input int n);
		repeat (n) send_word(8'(CH_0 + $urandom_range(9)), 1'b0);
	endtask

	task automatic send_random_number();
		if ($urandom_range(1))
			send_word(CH_MINUS, 1'b0);
		case ($urandom_range(7))
			0: begin
			end
			1: send_text("32767");
			2: send_text("32768");
			3: send_text("65535");
			4: send_text($sformatf("%0d", $urandom_range(99999, 65536)));
			default: send_digits($urandom_range(1, 5));
		endcase
		if ($urandom_range(1)) begin
			send_word(CH_DOT, 1'b0);
			send_digits($urandom_range(12));
		end
	endtask

	task automatic send_comment();
		send_word(CH_HASH, 1'b0);
		repeat ($urandom_range(6)) send_word(8'($urandom_range(255)), 1'b0);
		if ($urandom_range(7) == 0)
			send_word(8'($urandom_range(255)), 1'b1);
		else
			send_word(CH_LF, 1'b0);
	endtask

	task automatic send_terminator();
		case ($urandom_range(9))
			0: send_word(CH_SPACE, 1'b0);
			1: send_word(CH_TAB, 1'b0);
			2: send_word(CH_CR, 1'b0);
			3: send_word(CH_LF, 1'b0);
			4: send_comment();
			5: send_word(8'($urandom_range(255)), 1'b0);
			6: send_word(CH_MINUS, 1'b0);
			7: send_word(CH_DOT, 1'b0);
			8: send_word(8'($urandom_range(255)), 1'b1);
			default: send_word(CH_SPACE, 1'b0);
		endcase
	endtask

	initial begin : stimulus
		int   stop_at;
		int   choice;
		logic paused;
		paused = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// stray bytes at both ends of the range
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b0);
		// number ended by a stray byte: two results
		send_text("-1.5x");
		// second minus, then second point: no-digit numbers
		send_text("--..9 ");
		send_text("#a\n");
		// integer saturation flushed by end of text
		send_text("999999");
		send_word(8'hFF, 1'b1);
		// end of text with nothing open
		send_word(8'h00, 1'b1);
		send_word(CH_CR, 1'b0);

		in_valid = 1'b0;
		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		stop_at = words_sent + RANDOM_WORDS;
		while (words_sent < stop_at) begin
			idle_on = !(words_sent >= 700 && words_sent < 1000);
			if (!paused && words_sent >= PAUSE_AT) begin
				paused   = 1'b1;
				in_valid = 1'b0;
				wait (outstanding == 0);
				repeat (DRAIN_CYCLES) @(negedge clk);
			end
			choice = $urandom_range(99);
			if (choice < 70) begin
				send_random_number();
				send_terminator();
			end else if (choice < 85) begin
				send_comment();
			end else begin
				send_word(8'($urandom_range(255)), $urandom_range(15) == 0);
			end
		end
		in_valid = 1'b0;

		wait (outstanding == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
